FILE: design/r_type_execute_with_register_file_defines.svh
// assertion macros for the checker file of the r-type execute block
// no dependencies; clk and arst_n must exist in the scope of use
`ifndef R_TYPE_EXECUTE_WITH_REGISTER_FILE_DEFINES_SVH
`define R_TYPE_EXECUTE_WITH_REGISTER_FILE_DEFINES_SVH

// same-cycle implication
`define RTEX_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RTEX_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/rtex_pkg.sv
// constants, funct codes and result layout of the r-type execute block
// no dependencies
`default_nettype none

package rtex_pkg;

	localparam int unsigned REG_COUNT = 32;
	localparam int unsigned RF_AW     = $clog2(REG_COUNT);
	localparam int unsigned WORD_W    = 32;
	localparam int unsigned IDX_W     = 5;
	localparam int unsigned IN_W      = 32;
	localparam int unsigned OUT_W     = 80;

	localparam logic [5:0] OPC_RTYPE = 6'b000000;

	localparam logic [5:0] FN_ADD  = 6'b100000;
	localparam logic [5:0] FN_ADDU = 6'b100001;
	localparam logic [5:0] FN_SUB  = 6'b100010;
	localparam logic [5:0] FN_AND  = 6'b100100;
	localparam logic [5:0] FN_OR   = 6'b100101;
	localparam logic [5:0] FN_XOR  = 6'b100110;
	localparam logic [5:0] FN_NOR  = 6'b100111;
	localparam logic [5:0] FN_NAND = 6'b101000;
	localparam logic [5:0] FN_SLT  = 6'b101010;
	localparam logic [5:0] FN_SLL  = 6'b000000;
	localparam logic [5:0] FN_SRL  = 6'b000010;
	localparam logic [5:0] FN_SRA  = 6'b000011;
	localparam logic [5:0] FN_JR   = 6'b001000;

	typedef struct packed {
		logic              illegal;
		logic              overflow;
		logic [WORD_W-1:0] next_pc;
		logic              value_changed;
		logic [WORD_W-1:0] write_value;
		logic [IDX_W-1:0]  write_index;
		logic              write_enable;
	} result_t;

endpackage

`default_nettype wire

FILE: design/rtex_ram.sv
// generic synchronous ram: one write port, two registered read ports
// no dependencies
`default_nettype none

module rtex_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// read returns the old contents on a same-address write
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

`default_nettype wire

FILE: design/r_type_execute_with_register_file.sv
// Executes one MIPS-style R-type word per transfer against a register file of
// rtex_pkg::REG_COUNT words and a program counter. One instruction is taken
// every clock while the result channel does not stall. The instruction
// word and the ram reads are registered at the input transfer, and the result
// register follows them. The register file lives in synchronous
// rams that are read in the accept cycle. The write-back happens at the edge that
// registers the result, and the latest write is forwarded to the next
// instruction. While a result waits, one more instruction is held and then the
// input stalls. Register contents are tracked by per-entry valid bits,
// so the file reads as all zeros straight out of reset with no clearing pass.
// A cfg transfer loads the program counter and is taken in any cycle.
// Depends on rtex_pkg and rtex_ram.
`default_nettype none

module r_type_execute_with_register_file (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// configuration: start_pc
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [31:0]                 cfg_data,
	// s_tdata: instruction[31:0]
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [rtex_pkg::IN_W-1:0]   s_tdata,
	// m_tdata: write_enable[0], write_index[5:1], write_value[37:6],
	// value_changed[38], next_pc[70:39], overflow[71], illegal[72], zeros above
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic      [rtex_pkg::OUT_W-1:0]  m_tdata
);

	localparam int unsigned AW = rtex_pkg::RF_AW;
	localparam int unsigned WW = rtex_pkg::WORD_W;
	localparam int unsigned RW = $bits(rtex_pkg::result_t);

	logic                       s_acc;
	logic                       go_s1;
	logic                       valid_s1;
	logic [31:0]                ins_s1;
	logic                       out_valid_q;
	rtex_pkg::result_t          out_q;
	logic [WW-1:0]              pc_q;
	logic [rtex_pkg::REG_COUNT-1:0] rf_valid_q;
	logic                       fwd_en_q;
	logic [rtex_pkg::IDX_W-1:0] fwd_idx_q;
	logic [WW-1:0]              fwd_val_q;

	logic [WW-1:0]              ram_rs;
	logic [WW-1:0]              ram_rt;
	logic [WW-1:0]              ram_rd;
	logic [rtex_pkg::IDX_W-1:0] in_rs;
	logic [rtex_pkg::IDX_W-1:0] in_rt;
	logic [rtex_pkg::IDX_W-1:0] in_rd;

	logic [5:0]                 opcode;
	logic [rtex_pkg::IDX_W-1:0] rs;
	logic [rtex_pkg::IDX_W-1:0] rt;
	logic [rtex_pkg::IDX_W-1:0] rd;
	logic [4:0]                 shamt;
	logic [5:0]                 funct;
	logic [WW-1:0]              op_a;
	logic [WW-1:0]              op_b;
	logic [WW-1:0]              old_rd;
	logic [WW-1:0]              alu;
	logic                       ovf;
	logic                       bad;
	logic                       is_jr;
	logic                       wr;
	rtex_pkg::result_t          res;

	// register read: zero register, out-of-range index, forwarding, valid bit
	function automatic logic [WW-1:0] rf_read(
		input logic [rtex_pkg::IDX_W-1:0] idx,
		input logic [WW-1:0]              ram_data,
		input logic                       f_en,
		input logic [rtex_pkg::IDX_W-1:0] f_idx,
		input logic [WW-1:0]              f_val,
		input logic [rtex_pkg::REG_COUNT-1:0] vbits
	);
		logic [WW-1:0] v;
		v = '0;
		if (idx != '0 && 32'(idx) < rtex_pkg::REG_COUNT) begin
			if (f_en && f_idx == idx) begin
				v = f_val;
			end else if (vbits[idx[AW-1:0]]) begin
				v = ram_data;
			end
		end
		return v;
	endfunction

	assign cfg_ready = 1'b1;
	assign go_s1     = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || go_s1;
	assign s_acc     = s_tvalid && s_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {(rtex_pkg::OUT_W - RW)'(0), out_q};

	assign in_rs = s_tdata[25:21];
	assign in_rt = s_tdata[20:16];
	assign in_rd = s_tdata[15:11];

	assign opcode = ins_s1[31:26];
	assign rs     = ins_s1[25:21];
	assign rt     = ins_s1[20:16];
	assign rd     = ins_s1[15:11];
	assign shamt  = ins_s1[10:6];
	assign funct  = ins_s1[5:0];

	assign wr = go_s1 && res.write_enable;

	rtex_ram #(.WIDTH(WW), .DEPTH(rtex_pkg::REG_COUNT)) u_ram_src (
		.clk     (clk),
		.we      (wr),
		.waddr   (rd[AW-1:0]),
		.wdata   (res.write_value),
		.re      (s_acc),
		.raddr_a (in_rs[AW-1:0]),
		.raddr_b (in_rt[AW-1:0]),
		.rdata_a (ram_rs),
		.rdata_b (ram_rt)
	);

	// second copy serves the old destination value for value_changed
	rtex_ram #(.WIDTH(WW), .DEPTH(rtex_pkg::REG_COUNT)) u_ram_dst (
		.clk     (clk),
		.we      (wr),
		.waddr   (rd[AW-1:0]),
		.wdata   (res.write_value),
		.re      (s_acc),
		.raddr_a (in_rd[AW-1:0]),
		.raddr_b (in_rd[AW-1:0]),
		.rdata_a (ram_rd),
		.rdata_b ()
	);

	always_comb begin
		op_a   = rf_read(rs, ram_rs, fwd_en_q, fwd_idx_q, fwd_val_q, rf_valid_q);
		op_b   = rf_read(rt, ram_rt, fwd_en_q, fwd_idx_q, fwd_val_q, rf_valid_q);
		old_rd = rf_read(rd, ram_rd, fwd_en_q, fwd_idx_q, fwd_val_q, rf_valid_q);
		alu    = '0;
		ovf    = 1'b0;
		bad    = 1'b0;
		is_jr  = 1'b0;
		case (funct)
			rtex_pkg::FN_ADD: begin
				alu = op_a + op_b;
				ovf = ~(op_a[WW-1] ^ op_b[WW-1]) & (op_a[WW-1] ^ alu[WW-1]);
			end
			rtex_pkg::FN_ADDU: alu = op_a + op_b;
			rtex_pkg::FN_SUB: begin
				alu = op_a - op_b;
				ovf = (op_a[WW-1] ^ op_b[WW-1]) & (op_a[WW-1] ^ alu[WW-1]);
			end
			rtex_pkg::FN_AND:  alu = op_a & op_b;
			rtex_pkg::FN_OR:   alu = op_a | op_b;
			rtex_pkg::FN_XOR:  alu = op_a ^ op_b;
			rtex_pkg::FN_NOR:  alu = ~(op_a | op_b);
			rtex_pkg::FN_NAND: alu = ~(op_a & op_b);
			rtex_pkg::FN_SLT:  alu = WW'($signed(op_a) < $signed(op_b));
			rtex_pkg::FN_SLL:  alu = op_b << shamt;
			rtex_pkg::FN_SRL:  alu = op_b >> shamt;
			rtex_pkg::FN_SRA:  alu = $unsigned($signed(op_b) >>> shamt);
			rtex_pkg::FN_JR:   is_jr = 1'b1;
			default:           bad = 1'b1;
		endcase
		if (opcode != rtex_pkg::OPC_RTYPE) begin
			bad = 1'b1;
		end

		res = '0;
		if (bad) begin
			res.illegal = 1'b1;
			res.next_pc = pc_q;
		end else begin
			res.overflow = ovf;
			res.next_pc  = is_jr ? op_a : pc_q + WW'(4);
			if (!is_jr && rd != '0 && 32'(rd) < rtex_pkg::REG_COUNT) begin
				res.write_enable  = 1'b1;
				res.write_index   = rd;
				res.write_value   = alu;
				res.value_changed = old_rd != alu;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			pc_q        <= '0;
			rf_valid_q  <= '0;
			fwd_en_q    <= 1'b0;
		end else begin
			if (s_acc) begin
				valid_s1 <= 1'b1;
			end else if (go_s1) begin
				valid_s1 <= 1'b0;
			end
			if (go_s1) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				pc_q <= cfg_data;
			end else if (go_s1 && !res.illegal) begin
				pc_q <= res.next_pc;
			end
			if (wr) begin
				rf_valid_q[rd[AW-1:0]] <= 1'b1;
				fwd_en_q               <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_acc) begin
			ins_s1 <= s_tdata[31:0];
		end
		if (go_s1) begin
			out_q <= res;
		end
		// newest write, covers the read issued on the same edge
		if (wr) begin
			fwd_idx_q <= rd;
			fwd_val_q <= res.write_value;
		end
	end

endmodule

`default_nettype wire

FILE: design/rtex_checker.sv
// port-level checks on the result channel of the r-type execute block
// depends on r_type_execute_with_register_file_defines.svh and rtex_pkg
`default_nettype none
`include "r_type_execute_with_register_file_defines.svh"

module rtex_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       m_tvalid,
	input wire logic                       m_tready,
	input wire logic [rtex_pkg::OUT_W-1:0] m_tdata
);

	// stalled result holds
	`RTEX_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed under stall")

	// an illegal word writes nothing and flags no overflow
	`RTEX_ASSERT_IMP(a_illegal_quiet, m_tvalid && m_tdata[72], !m_tdata[0] && !m_tdata[71], "illegal word with side effects")

	// no write means zero write fields
	`RTEX_ASSERT_IMP(a_nowrite_zero, m_tvalid && !m_tdata[0], m_tdata[38:1] == '0, "write fields set without write")

	// register zero is never written
	`RTEX_ASSERT_IMP(a_no_r0_write, m_tvalid && m_tdata[0], m_tdata[5:1] != '0, "write to register zero")

endmodule

bind r_type_execute_with_register_file rtex_checker u_rtex_checker (.*);

`default_nettype wire

FILE: dv/r_type_execute_with_register_file_tb.sv
// self-checking testbench for the r-type execute block with register file
// keeps its own copy of the register file and program counter to predict each result
// depends on rtex_pkg and the r_type_execute_with_register_file rtl
`timescale 1ns / 1ps

module r_type_execute_with_register_file_tb;

	localparam int CLK_PERIOD     = 12;
	localparam int RESET_CYCLES   = 10;
	localparam int TIMEOUT_CYCLES = 500_000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int HOLD_CYCLES    = 300;

	// codes the block must reject, and the index of register zero
	localparam logic [5:0] FN_MULT     = 6'b011000;
	localparam logic [5:0] OPC_ILLEGAL = 6'b111111;
	localparam logic [4:0] R_ZERO      = 5'd0;

	localparam logic [5:0] LEGAL_FN [13] = '{rtex_pkg::FN_ADD, rtex_pkg::FN_ADDU,
		rtex_pkg::FN_SUB, rtex_pkg::FN_AND, rtex_pkg::FN_OR, rtex_pkg::FN_XOR,
		rtex_pkg::FN_NOR, rtex_pkg::FN_NAND, rtex_pkg::FN_SLT, rtex_pkg::FN_SLL,
		rtex_pkg::FN_SRL, rtex_pkg::FN_SRA, rtex_pkg::FN_JR};

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [31:0]                cfg_data  = '0;
	logic                       s_tvalid  = 1'b0;
	logic                       s_tready;
	logic [rtex_pkg::IN_W-1:0]  s_tdata   = '0;
	logic                       m_tvalid;
	logic                       m_tready  = 1'b0;
	logic [rtex_pkg::OUT_W-1:0] m_tdata;

	// predictor state
	logic [31:0]       gpr [32];
	logic [31:0]       pc_model;
	logic [31:0]       start_pc_model;
	rtex_pkg::result_t pending_results [$];
	int                fail_count = 0;

	// sender and receiver control
	int send_idle_pct = 0;
	int stall_pct     = 0;
	int hold_req      = 0;
	int hold_ack      = 0;
	int hold_left     = 0;

	r_type_execute_with_register_file dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic logic [31:0] read_gpr(input logic [4:0] idx);
		return (idx == R_ZERO || idx >= rtex_pkg::REG_COUNT) ? 32'd0 : gpr[idx];
	endfunction

	function automatic rtex_pkg::result_t execute_rtype(input logic [31:0] word);
		rtex_pkg::result_t r;
		logic [5:0]        opc, fn;
		logic [4:0]        rs, rt, rd, sh;
		logic [31:0]       a, b, v, npc;
		logic              bad, jump;
		opc  = word[31:26];
		rs   = word[25:21];
		rt   = word[20:16];
		rd   = word[15:11];
		sh   = word[10:6];
		fn   = word[5:0];
		a    = read_gpr(rs);
		b    = read_gpr(rt);
		v    = '0;
		npc  = pc_model + 32'd4;
		bad  = (opc != rtex_pkg::OPC_RTYPE);
		jump = 1'b0;
		r    = '0;
		if (!bad) begin
			case (fn)
				rtex_pkg::FN_ADD: begin
					v = a + b;
					r.overflow = ~(a[31] ^ b[31]) & (a[31] ^ v[31]);
				end
				rtex_pkg::FN_ADDU: v = a + b;
				rtex_pkg::FN_SUB: begin
					v = a - b;
					r.overflow = (a[31] ^ b[31]) & (a[31] ^ v[31]);
				end
				rtex_pkg::FN_AND:  v = a & b;
				rtex_pkg::FN_OR:   v = a | b;
				rtex_pkg::FN_XOR:  v = a ^ b;
				rtex_pkg::FN_NOR:  v = ~(a | b);
				rtex_pkg::FN_NAND: v = ~(a & b);
				rtex_pkg::FN_SLT:  v = {31'd0, $signed(a) < $signed(b)};
				rtex_pkg::FN_SLL:  v = b << sh;
				rtex_pkg::FN_SRL:  v = b >> sh;
				rtex_pkg::FN_SRA:  v = $signed(b) >>> sh;
				rtex_pkg::FN_JR: begin
					jump = 1'b1;
					npc  = a;
				end
				default: bad = 1'b1;
			endcase
		end
		if (bad) begin
			// rejected word leaves all state alone
			r.overflow = 1'b0;
			r.illegal  = 1'b1;
			r.next_pc  = pc_model;
		end else begin
			if (!jump && rd != R_ZERO && rd < rtex_pkg::REG_COUNT) begin
				r.write_enable  = 1'b1;
				r.write_index   = rd;
				r.write_value   = v;
				r.value_changed = (gpr[rd] != v);
				gpr[rd]         = v;
			end
			pc_model  = npc;
			r.next_pc = npc;
		end
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%08h, actual 0x%08h", name, want, got);
			fail_count++;
		end
	endtask

	// results are checked before new transfers are predicted in the same edge
	always @(posedge clk) begin
		rtex_pkg::result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[$bits(rtex_pkg::result_t)-1:0];
			if (pending_results.size() == 0) begin
				$error("result transfer with no instruction outstanding");
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				compare_field("write_enable", 32'(want.write_enable),
					32'(got.write_enable));
				compare_field("write_index", 32'(want.write_index),
					32'(got.write_index));
				compare_field("write_value", want.write_value, got.write_value);
				compare_field("value_changed", 32'(want.value_changed),
					32'(got.value_changed));
				compare_field("next_pc", want.next_pc, got.next_pc);
				compare_field("overflow", 32'(want.overflow), 32'(got.overflow));
				compare_field("illegal", 32'(want.illegal), 32'(got.illegal));
				compare_field("padding", '0,
					32'(m_tdata[rtex_pkg::OUT_W-1:$bits(rtex_pkg::result_t)]));
			end
		end
		if (arst_n && cfg_valid && cfg_ready) begin
			start_pc_model = cfg_data;
			pc_model       = cfg_data;
		end
		if (arst_n && s_tvalid && s_tready)
			pending_results.insert(pending_results.size(), execute_rtype(s_tdata));
	end

	// receiver: random stalls, or a long hold-off on request
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack  <= hold_req;
			hold_left <= HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	function automatic logic [31:0] rtype(input logic [5:0] fn, input int unsigned rs,
			input int unsigned rt, input int unsigned rd, input int unsigned sh);
		return {rtex_pkg::OPC_RTYPE, 5'(rs), 5'(rt), 5'(rd), 5'(sh), fn};
	endfunction

	function automatic logic [31:0] random_instr();
		logic [31:0] word;
		logic [5:0]  fn;
		int unsigned pick;
		word = $urandom();
		pick = $urandom_range(99);
		if (pick < 4) begin
			// raw word, left as drawn
		end else if (pick < 9) begin
			word[31:26] = 6'($urandom_range(63, 1));
		end else if (pick < 14) begin
			do fn = 6'($urandom());
			while (fn inside {rtex_pkg::FN_ADD, rtex_pkg::FN_ADDU, rtex_pkg::FN_SUB,
				rtex_pkg::FN_AND, rtex_pkg::FN_OR, rtex_pkg::FN_XOR, rtex_pkg::FN_NOR,
				rtex_pkg::FN_NAND, rtex_pkg::FN_SLT, rtex_pkg::FN_SLL, rtex_pkg::FN_SRL,
				rtex_pkg::FN_SRA, rtex_pkg::FN_JR});
			word[31:26] = rtex_pkg::OPC_RTYPE;
			word[5:0]   = fn;
		end else begin
			word[31:26] = rtex_pkg::OPC_RTYPE;
			word[5:0]   = LEGAL_FN[$urandom_range(12)];
		end
		return word;
	endfunction

	task automatic send_instr(input logic [31:0] word);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_start_pc(input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_directed();
		load_start_pc(32'hFFFF_FFFC);
		send_instr(rtype(rtex_pkg::FN_NOR, 0, 0, 1, 0));     // all ones, pc wraps to zero
		send_instr(rtype(rtex_pkg::FN_SRL, 31, 1, 2, 1));    // max positive, rs ignored
		send_instr(rtype(rtex_pkg::FN_SLL, 0, 1, 3, 31));    // most negative
		send_instr(rtype(rtex_pkg::FN_ADD, 2, 2, 4, 0));     // positive overflow
		send_instr(rtype(rtex_pkg::FN_ADD, 3, 3, 5, 0));     // negative overflow, same value
		send_instr(rtype(rtex_pkg::FN_SUB, 3, 2, 6, 0));
		send_instr(rtype(rtex_pkg::FN_SUB, 2, 3, 7, 0));
		send_instr(rtype(rtex_pkg::FN_ADDU, 1, 1, 8, 0));
		send_instr(rtype(rtex_pkg::FN_AND, 1, 2, 9, 0));
		send_instr(rtype(rtex_pkg::FN_OR, 3, 2, 10, 0));
		send_instr(rtype(rtex_pkg::FN_XOR, 1, 2, 11, 0));
		send_instr(rtype(rtex_pkg::FN_NAND, 1, 1, 12, 0));
		send_instr(rtype(rtex_pkg::FN_SLT, 3, 2, 13, 0));
		send_instr(rtype(rtex_pkg::FN_SLT, 2, 3, 14, 0));
		send_instr(rtype(rtex_pkg::FN_SRA, 0, 3, 15, 31));
		send_instr(rtype(rtex_pkg::FN_SRA, 0, 2, 16, 4));
		send_instr(rtype(rtex_pkg::FN_SLL, 0, 2, 17, 0));
		send_instr(rtype(rtex_pkg::FN_ADD, 1, 1, 0, 0));      // register zero stays zero
		send_instr(rtype(rtex_pkg::FN_OR, 2, 0, 2, 0));       // rewrite with the same value
		send_instr(rtype(rtex_pkg::FN_ADD, 31, 31, 18, 31));  // shamt ignored
		send_instr(rtype(rtex_pkg::FN_JR, 2, 31, 31, 31));    // unaligned jump target
		send_instr({OPC_ILLEGAL, 5'd1, 5'd1, 5'd20, 5'd0, rtex_pkg::FN_ADD});
		send_instr(rtype(FN_MULT, 1, 2, 21, 0));
		send_instr(rtype(rtex_pkg::FN_JR, 1, 0, 0, 0));
		send_instr(rtype(rtex_pkg::FN_ADDU, 2, 0, 19, 0));    // pc wraps past the top
		drain();
	endtask

	task automatic test_random_traffic(input int count, input int idle, input int stall,
			input logic [31:0] new_pc);
		load_start_pc(new_pc);
		send_idle_pct = idle;
		stall_pct    <= stall;
		repeat (count) send_instr(random_instr());
		drain();
	endtask

	// long receiver hold-off with the sender pushing, so the input stalls
	task automatic test_output_stall();
		send_idle_pct = 0;
		stall_pct    <= 0;
		hold_req     <= hold_req + 1;
		repeat (100) send_instr(random_instr());
		drain();
	endtask

	initial begin
		foreach (gpr[i]) gpr[i] = '0;
		start_pc_model = '0;
		pc_model       = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_traffic(280, 0, 0, 32'h0000_0000);
		test_random_traffic(280, 83, 0, 32'h0000_0004);
		test_random_traffic(280, 0, 83, {$urandom() & 32'hFFFF_FFFC});
		test_random_traffic(280, 26, 26, 32'hFFFF_FFFC);
		test_output_stall();

		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("FAILED: results differ");
		$finish;
	end

endmodule

FILE: files.f
+incdir+design
design/rtex_pkg.sv
design/rtex_ram.sv
design/r_type_execute_with_register_file.sv
design/rtex_checker.sv
dv/r_type_execute_with_register_file_tb.sv
